// ===== rtl/mi3_pkg.sv =====
// ----------------------------------------------------------------------------
// mi3_pkg: shared types and constants of the 3x3 matrix inverse
// Fixed-point format, pipeline depths, cofactor index tables and the
// records that pass between the front end, the divider lanes and the merge.
// ----------------------------------------------------------------------------
package mi3_pkg;

	localparam int FRAC_BITS = 16;
	localparam int ELEM_W    = 32;
	localparam int ADJ_W     = 2 * ELEM_W;
	localparam int DET_W     = 3 * ELEM_W + 1;
	localparam int THR_W     = 31;
	localparam int N_ELEM    = 9;

	// Quotient bits resolved by the divider lanes, one per stage.
	localparam int DIV_STEPS = ELEM_W;
	localparam int NUM_W     = ADJ_W + 2 * FRAC_BITS;

	localparam int FRONT_LAT = 8;
	localparam int LANE_LAT  = DIV_STEPS + 1;
	localparam int MERGE_LAT = 1;
	localparam int TOTAL_LAT = FRONT_LAT + LANE_LAT + MERGE_LAT;

	localparam int PADDR_W = 3;
	localparam logic [PADDR_W-3:0] REG_THRESHOLD = '0;
	localparam logic [THR_W-1:0]   THR_RESET     = THR_W'(1);

	localparam logic [ELEM_W-1:0] SAT_POS = {1'b0, {(ELEM_W-1){1'b1}}};
	localparam logic [ELEM_W-1:0] SAT_NEG = {1'b1, {(ELEM_W-1){1'b0}}};

	// Adjugate entry k = m[A]*m[B] - m[C]*m[D], row-major element indexes.
	localparam int COF_A [N_ELEM] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
	localparam int COF_B [N_ELEM] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
	localparam int COF_C [N_ELEM] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
	localparam int COF_D [N_ELEM] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

	typedef struct packed {
		logic [ADJ_W-1:0] mag;
		logic             neg;
	} lane_in_t;

	typedef struct packed {
		logic [DIV_STEPS-1:0] quo;
		logic                 neg;
		logic                 big;
	} lane_out_t;

endpackage

// ===== rtl/mi3_front.sv =====
// ----------------------------------------------------------------------------
// mi3_front: cofactors, determinant and singularity test
// Eight pipeline stages from the registered matrix to the adjugate
// magnitudes, the determinant magnitude and the singular flag.
// ----------------------------------------------------------------------------
module mi3_front import mi3_pkg::*; (
	input  logic                     clk,
	input  logic signed [ELEM_W-1:0] elem [N_ELEM],
	input  logic [THR_W-1:0]         thr,
	output lane_in_t                 lane_in [N_ELEM],
	output logic [DET_W-1:0]         dmag,
	output logic                     singular
);

	logic signed [ELEM_W-1:0] m_s1   [N_ELEM];
	logic signed [ADJ_W-1:0]  prod_s2 [2*N_ELEM];
	logic signed [ELEM_W-1:0] row_s2 [3];
	logic signed [ELEM_W-1:0] row_s3 [3];
	logic signed [ADJ_W-1:0]  adj_s3 [N_ELEM];
	logic signed [ADJ_W-1:0]  adj_s4 [N_ELEM];
	logic signed [ADJ_W-1:0]  adj_s5 [N_ELEM];
	logic signed [ADJ_W-1:0]  adj_s6 [N_ELEM];
	logic signed [ADJ_W-1:0]  pph_s4 [3];
	logic signed [ADJ_W:0]    ppl_s4 [3];
	logic signed [DET_W-1:0]  term_s5 [3];
	logic signed [DET_W-1:0]  det_s6;
	logic [DET_W-1:0]         dmag_s7;
	logic                     dneg_s7;
	logic                     dzero_s7;
	logic [ADJ_W-1:0]         mag_s7 [N_ELEM];
	logic                     asgn_s7 [N_ELEM];
	lane_in_t                 lane_s8 [N_ELEM];
	logic [DET_W-1:0]         dmag_s8;
	logic                     singular_s8;
	logic [DET_W-1:0]         thr_ext;

	assign thr_ext = DET_W'(thr) << (2 * FRAC_BITS);

	always_ff @(posedge clk) begin
		for (int k = 0; k < N_ELEM; k++) begin
			m_s1[k] <= elem[k];
			prod_s2[2*k]   <= m_s1[COF_A[k]] * m_s1[COF_B[k]];
			prod_s2[2*k+1] <= m_s1[COF_C[k]] * m_s1[COF_D[k]];
			adj_s3[k] <= prod_s2[2*k] - prod_s2[2*k+1];
			adj_s4[k] <= adj_s3[k];
			adj_s5[k] <= adj_s4[k];
			adj_s6[k] <= adj_s5[k];
			asgn_s7[k] <= adj_s6[k][ADJ_W-1];
			mag_s7[k]  <= adj_s6[k][ADJ_W-1] ? ADJ_W'(-adj_s6[k]) : ADJ_W'(adj_s6[k]);
			lane_s8[k].mag <= mag_s7[k];
			lane_s8[k].neg <= asgn_s7[k] ^ dneg_s7;
		end
		for (int j = 0; j < 3; j++) begin
			row_s2[j] <= m_s1[j];
			row_s3[j] <= row_s2[j];
			// First-row expansion, each element times its 64-bit cofactor in two halves.
			pph_s4[j] <= row_s3[j] * $signed(adj_s3[3*j][ADJ_W-1:ELEM_W]);
			ppl_s4[j] <= row_s3[j] * $signed({1'b0, adj_s3[3*j][ELEM_W-1:0]});
			term_s5[j] <= (DET_W'(pph_s4[j]) <<< ELEM_W) + DET_W'(ppl_s4[j]);
		end
		det_s6   <= term_s5[0] + term_s5[1] + term_s5[2];
		dneg_s7  <= det_s6[DET_W-1];
		dzero_s7 <= (det_s6 == '0);
		dmag_s7  <= det_s6[DET_W-1] ? DET_W'(-det_s6) : DET_W'(det_s6);
		dmag_s8  <= dmag_s7;
		singular_s8 <= dzero_s7 | (dmag_s7 < thr_ext);
	end

	assign lane_in  = lane_s8;
	assign dmag     = dmag_s8;
	assign singular = singular_s8;

endmodule

// ===== rtl/mi3_div_lane.sv =====
// ----------------------------------------------------------------------------
// mi3_div_lane: pipelined restoring divider for one inverse element
// Divides the adjugate magnitude, scaled by the squared fraction, by the
// determinant magnitude, one quotient bit per stage.
// ----------------------------------------------------------------------------
module mi3_div_lane import mi3_pkg::*; (
	input  logic             clk,
	input  lane_in_t         lane_in,
	input  logic [DET_W-1:0] dmag_d [DIV_STEPS+1],
	output lane_out_t        lane_out
);

	logic [NUM_W-1:0]     num;
	logic [DET_W-1:0]     rem_s [DIV_STEPS+1];
	logic [DIV_STEPS-1:0] low_s [DIV_STEPS+1];
	logic                 neg_s [DIV_STEPS+1];
	logic                 big_s [DIV_STEPS+1];

	assign num = {lane_in.mag, {(2*FRAC_BITS){1'b0}}};

	// The high part at or above the divisor means a quotient of 2^32 or more.
	always_ff @(posedge clk) begin
		rem_s[0] <= DET_W'(num[NUM_W-1:DIV_STEPS]);
		low_s[0] <= num[DIV_STEPS-1:0];
		neg_s[0] <= lane_in.neg;
		big_s[0] <= (DET_W'(num[NUM_W-1:DIV_STEPS]) >= dmag_d[0]);
	end

	for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_step
		logic [DET_W:0] trial;
		logic           fit;

		assign trial = {rem_s[k-1], low_s[k-1][DIV_STEPS-1]};
		assign fit   = (trial >= {1'b0, dmag_d[k]});

		always_ff @(posedge clk) begin
			rem_s[k] <= fit ? DET_W'(trial - {1'b0, dmag_d[k]}) : trial[DET_W-1:0];
			low_s[k] <= {low_s[k-1][DIV_STEPS-2:0], fit};
			neg_s[k] <= neg_s[k-1];
			big_s[k] <= big_s[k-1];
		end
	end

	assign lane_out.quo = low_s[DIV_STEPS];
	assign lane_out.neg = neg_s[DIV_STEPS];
	assign lane_out.big = big_s[DIV_STEPS];

endmodule

// ===== rtl/mi3_merge.sv =====
// ----------------------------------------------------------------------------
// mi3_merge: saturation and flag merge
// Applies sign and saturation to each lane, forces zeros for a singular
// matrix and combines the lane overflows into one flag.
// ----------------------------------------------------------------------------
module mi3_merge import mi3_pkg::*; (
	input  logic              clk,
	input  lane_out_t         lane_out [N_ELEM],
	input  logic              singular_in,
	output logic [ELEM_W-1:0] inv [N_ELEM],
	output logic              singular,
	output logic              overflow
);

	logic [ELEM_W-1:0] val   [N_ELEM];
	logic [N_ELEM-1:0] sat;
	logic [ELEM_W-1:0] inv_q [N_ELEM];
	logic              singular_q;
	logic              overflow_q;

	always_comb begin
		for (int k = 0; k < N_ELEM; k++) begin
			if (lane_out[k].neg) begin
				sat[k] = lane_out[k].big || (lane_out[k].quo > SAT_NEG);
				val[k] = sat[k] ? SAT_NEG : ELEM_W'(-lane_out[k].quo);
			end else begin
				sat[k] = lane_out[k].big || lane_out[k].quo[ELEM_W-1];
				val[k] = sat[k] ? SAT_POS : lane_out[k].quo;
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < N_ELEM; k++) begin
			inv_q[k] <= singular_in ? '0 : val[k];
		end
		singular_q <= singular_in;
		overflow_q <= !singular_in && (|sat);
	end

	assign inv      = inv_q;
	assign singular = singular_q;
	assign overflow = overflow_q;

endmodule

// ===== rtl/matrix_inverse_3x3_top.sv =====
// ----------------------------------------------------------------------------
// matrix_inverse_3x3_top: 3x3 fixed-point matrix inverse by the adjugate
// The result strobe done rises at the edge before the one that takes the result.
// Throughput: one request per cycle; busy never rises, so start may be held.
// The latency is set by the 32-stage divider lanes plus the cofactor front end.
// The receiver cannot stall: each result is shown for exactly one cycle.
// Reset clears the request pipeline and sets the threshold to 1.
// ----------------------------------------------------------------------------
module matrix_inverse_3x3_top import mi3_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [PADDR_W-1:0]       paddr,
	input  logic [31:0]              pwdata,
	output logic [31:0]              prdata,
	output logic                     pready,
	input  logic                     start,
	output logic                     busy,
	input  logic signed [ELEM_W-1:0] elem_r0c0,
	input  logic signed [ELEM_W-1:0] elem_r0c1,
	input  logic signed [ELEM_W-1:0] elem_r0c2,
	input  logic signed [ELEM_W-1:0] elem_r1c0,
	input  logic signed [ELEM_W-1:0] elem_r1c1,
	input  logic signed [ELEM_W-1:0] elem_r1c2,
	input  logic signed [ELEM_W-1:0] elem_r2c0,
	input  logic signed [ELEM_W-1:0] elem_r2c1,
	input  logic signed [ELEM_W-1:0] elem_r2c2,
	output logic                     done,
	output logic signed [ELEM_W-1:0] inv_r0c0,
	output logic signed [ELEM_W-1:0] inv_r0c1,
	output logic signed [ELEM_W-1:0] inv_r0c2,
	output logic signed [ELEM_W-1:0] inv_r1c0,
	output logic signed [ELEM_W-1:0] inv_r1c1,
	output logic signed [ELEM_W-1:0] inv_r1c2,
	output logic signed [ELEM_W-1:0] inv_r2c0,
	output logic signed [ELEM_W-1:0] inv_r2c1,
	output logic signed [ELEM_W-1:0] inv_r2c2,
	output logic                     singular,
	output logic                     overflow
);

	// Configuration register. The single threshold register sits at word
	// address 0 (byte addresses 0 to 3); writes to other addresses are dropped and read as zero.
	logic [THR_W-1:0]   thr_q;
	logic [PADDR_W-3:0] reg_idx;
	logic               cfg_wr;

	assign pready  = 1'b1;
	assign reg_idx = paddr[PADDR_W-1:2];
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign prdata  = (reg_idx == REG_THRESHOLD) ? {1'b0, thr_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
		end else if (cfg_wr && reg_idx == REG_THRESHOLD) begin
			thr_q <= pwdata[THR_W-1:0];
		end
	end

	// The datapath is a free-running pipeline, so a request is taken in
	// every cycle and only a valid bit follows it down to the result strobe.
	logic                 accept;
	logic [TOTAL_LAT-1:0] vld_q;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[TOTAL_LAT-2:0], accept};
		end
	end

	assign done = vld_q[TOTAL_LAT-1];

	// Front end: products, cofactors, determinant and the singular test.
	logic signed [ELEM_W-1:0] elem [N_ELEM];
	lane_in_t                 lane_in [N_ELEM];
	logic [DET_W-1:0]         dmag;
	logic                     front_singular;

	assign elem[0] = elem_r0c0;
	assign elem[1] = elem_r0c1;
	assign elem[2] = elem_r0c2;
	assign elem[3] = elem_r1c0;
	assign elem[4] = elem_r1c1;
	assign elem[5] = elem_r1c2;
	assign elem[6] = elem_r2c0;
	assign elem[7] = elem_r2c1;
	assign elem[8] = elem_r2c2;

	mi3_front u_front (
		.clk      (clk),
		.elem     (elem),
		.thr      (thr_q),
		.lane_in  (lane_in),
		.dmag     (dmag),
		.singular (front_singular)
	);

	// The determinant magnitude is shared by all nine lanes, so one delay
	// line feeds every divider stage. The singular flag rides alongside
	// until the merge.
	logic [DET_W-1:0] dmag_d  [DIV_STEPS+1];
	logic             sing_q  [LANE_LAT];

	assign dmag_d[0] = dmag;

	for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_dmag
		always_ff @(posedge clk) begin
			dmag_d[k] <= dmag_d[k-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < LANE_LAT; k++) begin
				sing_q[k] <= 1'b0;
			end
		end else begin
			sing_q[0] <= front_singular;
			for (int k = 1; k < LANE_LAT; k++) begin
				sing_q[k] <= sing_q[k-1];
			end
		end
	end

	// Nine divider lanes, one per inverse element.
	lane_out_t lane_out [N_ELEM];

	for (genvar k = 0; k < N_ELEM; k++) begin : g_lane
		mi3_div_lane u_lane (
			.clk      (clk),
			.lane_in  (lane_in[k]),
			.dmag_d   (dmag_d),
			.lane_out (lane_out[k])
		);
	end

	// Merge: sign, saturation, zeroing and the overflow flag.
	logic [ELEM_W-1:0] inv [N_ELEM];

	mi3_merge u_merge (
		.clk         (clk),
		.lane_out    (lane_out),
		.singular_in (sing_q[LANE_LAT-1]),
		.inv         (inv),
		.singular    (singular),
		.overflow    (overflow)
	);

	assign inv_r0c0 = inv[0];
	assign inv_r0c1 = inv[1];
	assign inv_r0c2 = inv[2];
	assign inv_r1c0 = inv[3];
	assign inv_r1c1 = inv[4];
	assign inv_r1c2 = inv[5];
	assign inv_r2c0 = inv[6];
	assign inv_r2c1 = inv[7];
	assign inv_r2c2 = inv[8];

endmodule

// ===== rtl/mi3_checker.sv =====
// ----------------------------------------------------------------------------
// mi3_checker: port-level checks of the 3x3 matrix inverse
// Watches request timing, the singular result and the saturation flag.
// ----------------------------------------------------------------------------
module mi3_checker import mi3_pkg::*; (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     start,
	input logic                     busy,
	input logic                     done,
	input logic signed [ELEM_W-1:0] inv_r0c0,
	input logic signed [ELEM_W-1:0] inv_r0c1,
	input logic signed [ELEM_W-1:0] inv_r0c2,
	input logic signed [ELEM_W-1:0] inv_r1c0,
	input logic signed [ELEM_W-1:0] inv_r1c1,
	input logic signed [ELEM_W-1:0] inv_r1c2,
	input logic signed [ELEM_W-1:0] inv_r2c0,
	input logic signed [ELEM_W-1:0] inv_r2c1,
	input logic signed [ELEM_W-1:0] inv_r2c2,
	input logic                     singular,
	input logic                     overflow
);

	// Every request taken produces its result a fixed time later.
	a_req_to_result: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##TOTAL_LAT done)
		else $error("request without result");

	// No result appears without a request taken at the matching time.
	a_result_has_req: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, TOTAL_LAT))
		else $error("result without request");

	// A singular result carries all zeros and no overflow.
	a_singular_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && singular |-> !overflow && inv_r0c0 == '0 && inv_r0c1 == '0 &&
			inv_r0c2 == '0 && inv_r1c0 == '0 && inv_r1c1 == '0 && inv_r1c2 == '0 &&
			inv_r2c0 == '0 && inv_r2c1 == '0 && inv_r2c2 == '0)
		else $error("singular result not cleared");

	// Overflow means at least one element sits at a saturation limit.
	a_overflow_sat: assert property (@(posedge clk) disable iff (!arst_n)
		done && overflow |->
			inv_r0c0 == SAT_POS || inv_r0c0 == SAT_NEG ||
			inv_r0c1 == SAT_POS || inv_r0c1 == SAT_NEG ||
			inv_r0c2 == SAT_POS || inv_r0c2 == SAT_NEG ||
			inv_r1c0 == SAT_POS || inv_r1c0 == SAT_NEG ||
			inv_r1c1 == SAT_POS || inv_r1c1 == SAT_NEG ||
			inv_r1c2 == SAT_POS || inv_r1c2 == SAT_NEG ||
			inv_r2c0 == SAT_POS || inv_r2c0 == SAT_NEG ||
			inv_r2c1 == SAT_POS || inv_r2c1 == SAT_NEG ||
			inv_r2c2 == SAT_POS || inv_r2c2 == SAT_NEG)
		else $error("overflow without saturated element");

endmodule

bind matrix_inverse_3x3_top mi3_checker u_mi3_checker (.*);
